### hw/rtl/dhsc_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the disk head seek controller.
package dhsc_pkg;

  typedef enum logic [1:0] {
    PHASE_IDLE,
    PHASE_HOMING,
    PHASE_SEEKING
  } phase_t;

  localparam logic [1:0] KIND_SEEK  = 2'd0;
  localparam logic [1:0] KIND_RECAL = 2'd1;
  localparam logic [1:0] KIND_SLOT  = 2'd2;

  localparam logic [0:0] REG_HOME_STEP_LIMIT      = 1'd0;
  localparam logic [0:0] REG_INNER_TRACK_BOUNDARY = 1'd1;

  localparam logic [7:0] HOME_STEP_LIMIT_RESET      = 8'd100;
  localparam logic [7:0] INNER_TRACK_BOUNDARY_RESET = 8'd43;

endpackage

### hw/rtl/disk_head_seek_controller.sv
`timescale 1ns / 1ps
// Disk head seek controller: homing and seek sequencer with one result per request.
// The result of a request is registered and is on the outputs in the cycle after it is accepted.
// Throughput: one request per cycle while the receiver takes results; the single result register limits the rate.
// A new request is accepted whenever the result register is empty or being drained.
// Synchronous reset returns to idle, unhomed, track 0, registers at 100 and 43.
module disk_head_seek_controller #(
  parameter int TRACK_WIDTH = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [0:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] kind,
  input  logic [7:0] target_track,
  input  logic       track0_sensor,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       step_valid,
  output logic       step_direction,
  output logic       busy_res,
  output logic       done_res,
  output logic       drive_found,
  output logic [7:0] head_track,
  output logic       inner_track_level
);
  import dhsc_pkg::*;

  localparam int CMP_W = (TRACK_WIDTH > 8) ? TRACK_WIDTH : 8;

  logic [7:0] home_step_limit;
  logic [7:0] inner_track_boundary;

  phase_t                 phase, phase_next;
  logic                   homed_flag, homed_flag_next;
  logic [TRACK_WIDTH-1:0] track_position, track_position_next;
  logic [TRACK_WIDTH-1:0] goal_track, goal_track_next;
  logic [7:0]             homing_steps, homing_steps_next;
  logic                   found_flag, found_flag_next;
  logic                   inner_level, inner_level_next;

  logic                   accept;
  logic                   busy_now;
  logic                   step_now;
  logic                   dir_now;
  logic                   done_now;
  logic                   busy_after;
  logic                   goal_inner;
  logic [TRACK_WIDTH-1:0] slot_pos;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign busy_now  = (phase == PHASE_HOMING) || (phase == PHASE_SEEKING);

  always_ff @(posedge clk) begin
    if (rst) begin
      home_step_limit      <= HOME_STEP_LIMIT_RESET;
      inner_track_boundary <= INNER_TRACK_BOUNDARY_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_HOME_STEP_LIMIT:      home_step_limit      <= cfg_data;
        REG_INNER_TRACK_BOUNDARY: inner_track_boundary <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next state: the whole state update for one request.
  always_comb begin
    phase_next          = phase;
    homed_flag_next     = homed_flag;
    track_position_next = track_position;
    goal_track_next     = goal_track;
    homing_steps_next   = homing_steps;
    found_flag_next     = found_flag;
    inner_level_next    = inner_level;
    step_now            = 1'b0;
    dir_now             = 1'b0;
    done_now            = 1'b0;
    slot_pos            = track_position;
    goal_inner          = 1'b0;
    if (accept) begin
      unique case (kind)
        KIND_SEEK: begin
          if (!busy_now) begin
            goal_track_next = TRACK_WIDTH'(target_track);
            goal_inner = CMP_W'(goal_track_next) < CMP_W'(inner_track_boundary);
            if (!homed_flag || goal_track_next == '0) begin
              phase_next        = PHASE_HOMING;
              homing_steps_next = 8'd0;
            end else if (track_position == goal_track_next) begin
              // Already on the requested track: completes right away.
              phase_next       = PHASE_IDLE;
              done_now         = 1'b1;
              inner_level_next = goal_inner;
            end else begin
              phase_next = PHASE_SEEKING;
            end
          end
        end
        KIND_RECAL: begin
          if (!busy_now) begin
            homed_flag_next   = 1'b0;
            goal_track_next   = '0;
            phase_next        = PHASE_HOMING;
            homing_steps_next = 8'd0;
          end
        end
        KIND_SLOT: begin
          goal_inner = CMP_W'(goal_track) < CMP_W'(inner_track_boundary);
          unique case (phase)
            PHASE_HOMING: begin
              if (homing_steps >= home_step_limit || track0_sensor) begin
                // The limit check wins over the sensor.
                found_flag_next     = (homing_steps < home_step_limit);
                homed_flag_next     = 1'b1;
                track_position_next = '0;
                if (goal_track == '0) begin
                  phase_next       = PHASE_IDLE;
                  done_now         = 1'b1;
                  inner_level_next = goal_inner;
                end else begin
                  phase_next = PHASE_SEEKING;
                end
              end else begin
                step_now          = 1'b1;
                homing_steps_next = homing_steps + 8'd1;
              end
            end
            PHASE_SEEKING: begin
              slot_pos = track0_sensor ? '0 : track_position;
              if (goal_track > slot_pos) begin
                step_now            = 1'b1;
                dir_now             = 1'b1;
                track_position_next = slot_pos + TRACK_WIDTH'(1);
              end else if (goal_track < slot_pos) begin
                step_now            = 1'b1;
                track_position_next = slot_pos - TRACK_WIDTH'(1);
              end else begin
                track_position_next = slot_pos;
              end
              if (track_position_next == goal_track) begin
                phase_next       = PHASE_IDLE;
                done_now         = 1'b1;
                inner_level_next = goal_inner;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // Outputs: status as seen after the update.
  always_comb begin
    busy_after = (phase_next == PHASE_HOMING) || (phase_next == PHASE_SEEKING);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PHASE_IDLE;
      homed_flag     <= 1'b0;
      track_position <= '0;
      goal_track     <= '0;
      homing_steps   <= 8'd0;
      found_flag     <= 1'b0;
      inner_level    <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      phase          <= phase_next;
      homed_flag     <= homed_flag_next;
      track_position <= track_position_next;
      goal_track     <= goal_track_next;
      homing_steps   <= homing_steps_next;
      found_flag     <= found_flag_next;
      inner_level    <= inner_level_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      step_valid        <= step_now;
      step_direction    <= dir_now;
      busy_res          <= busy_after;
      done_res          <= done_now;
      drive_found       <= found_flag_next;
      head_track        <= 8'(track_position_next);
      inner_track_level <= inner_level_next;
    end
  end

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res)
    else $error("seek reported done while still busy");

  a_step_dir_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !step_valid |-> !step_direction)
    else $error("step direction set without a step");

  a_seek_homed: assert property (@(posedge clk) disable iff (rst)
    phase == PHASE_SEEKING |-> homed_flag)
    else $error("seeking without a homed head");

  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken while result register is stalled");

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the disk head seek controller, with a built-in head state predictor.
module tb_top;
  import dhsc_pkg::*;

  localparam int TRACK_W = 8;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic       step;
    logic       dir;
    logic       busy;
    logic       done;
    logic       found;
    logic [7:0] track;
    logic       inner;
  } head_status_t;

  logic       clk;
  logic       rst;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [0:0] cfg_index;
  logic [7:0] cfg_data;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] kind;
  logic [7:0] target_track;
  logic       track0_sensor;
  logic       out_valid;
  logic       out_ready;
  logic       step_valid;
  logic       step_direction;
  logic       busy_res;
  logic       done_res;
  logic       drive_found;
  logic [7:0] head_track;
  logic       inner_track_level;

  // Predicted controller state and register copies.
  phase_t             hd_phase;
  logic               hd_homed;
  logic [TRACK_W-1:0] hd_pos;
  logic [TRACK_W-1:0] hd_goal;
  logic [7:0]         hd_home_steps;
  logic               hd_found;
  logic               hd_inner;
  logic [7:0]         step_limit;
  logic [7:0]         inner_boundary;

  head_status_t status_q[$];
  int mismatch_count = 0;
  int requests_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_cycles = 0;

  disk_head_seek_controller #(
    .TRACK_WIDTH(TRACK_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .kind(kind),
    .target_track(target_track),
    .track0_sensor(track0_sensor),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .step_valid(step_valid),
    .step_direction(step_direction),
    .busy_res(busy_res),
    .done_res(done_res),
    .drive_found(drive_found),
    .head_track(head_track),
    .inner_track_level(inner_track_level)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic seek_arrived();
    if (hd_pos == hd_goal) begin
      hd_inner = (hd_goal < inner_boundary);
      hd_phase = PHASE_IDLE;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void begin_seek(logic [7:0] goal);
    hd_goal = goal[TRACK_W-1:0];
    if (!hd_homed || hd_goal == '0) begin
      hd_phase = PHASE_HOMING;
      hd_home_steps = '0;
    end else begin
      hd_phase = PHASE_SEEKING;
    end
  endfunction

  function automatic head_status_t advance_head(logic [1:0] k, logic [7:0] tgt, logic sens);
    head_status_t r;
    logic busy_now;
    r = '0;
    busy_now = (hd_phase == PHASE_HOMING) || (hd_phase == PHASE_SEEKING);
    case (k)
      KIND_SEEK: begin
        if (!busy_now) begin
          begin_seek(tgt);
          if (hd_phase == PHASE_SEEKING) r.done = seek_arrived();
        end
      end
      KIND_RECAL: begin
        if (!busy_now) begin
          hd_homed = 1'b0;
          begin_seek(8'd0);
        end
      end
      KIND_SLOT: begin
        if (hd_phase == PHASE_HOMING) begin
          // Once the limit is reached the sensor is not looked at.
          if (hd_home_steps >= step_limit || sens) begin
            hd_found = (hd_home_steps < step_limit);
            hd_homed = 1'b1;
            hd_pos = '0;
            hd_phase = PHASE_SEEKING;
            r.done = seek_arrived();
          end else begin
            r.step = 1'b1;
            hd_home_steps++;
          end
        end else if (hd_phase == PHASE_SEEKING) begin
          if (sens) hd_pos = '0;
          if (hd_goal > hd_pos) begin
            r.step = 1'b1;
            r.dir = 1'b1;
            hd_pos++;
          end else if (hd_goal < hd_pos) begin
            r.step = 1'b1;
            hd_pos--;
          end
          r.done = seek_arrived();
        end
      end
      default: ;
    endcase
    r.busy = (hd_phase == PHASE_HOMING) || (hd_phase == PHASE_SEEKING);
    r.found = hd_found;
    r.track = 8'(hd_pos);
    r.inner = hd_inner;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [7:0] exp_v, logic [7:0] got_v);
    mismatch_count++;
    if (mismatch_count <= 100)
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, exp_v, got_v);
  endtask

  // Receiver: random stalls, plus an optional long hold-off counted here.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        out_ready <= 1'b0;
        hold_off_cycles--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    head_status_t exp_s;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (status_q.size() == 0) begin
        report_mismatch("result with no request pending", 8'd0, 8'd1);
      end else begin
        exp_s = status_q.pop_front();
        if (step_valid !== exp_s.step)
          report_mismatch("step_valid", 8'(exp_s.step), 8'(step_valid));
        if (step_direction !== exp_s.dir)
          report_mismatch("step_direction", 8'(exp_s.dir), 8'(step_direction));
        if (busy_res !== exp_s.busy)
          report_mismatch("busy_res", 8'(exp_s.busy), 8'(busy_res));
        if (done_res !== exp_s.done)
          report_mismatch("done_res", 8'(exp_s.done), 8'(done_res));
        if (drive_found !== exp_s.found)
          report_mismatch("drive_found", 8'(exp_s.found), 8'(drive_found));
        if (head_track !== exp_s.track) report_mismatch("head_track", exp_s.track, head_track);
        if (inner_track_level !== exp_s.inner)
          report_mismatch("inner_track_level", 8'(exp_s.inner), 8'(inner_track_level));
      end
    end
  end

  task automatic send_request(logic [1:0] k, logic [7:0] tgt, logic sens);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    target_track <= tgt;
    track0_sensor <= sens;
    do @(posedge clk); while (!in_ready);
    status_q.push_back(advance_head(k, tgt, sens));
    requests_sent++;
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_HOME_STEP_LIMIT) step_limit = val;
    else inner_boundary = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly complete seek and recalibrate sequences, with some stray requests mixed in.
  task automatic run_traffic(int n_req, int send_pct, int recv_pct);
    int stop_at;
    int r;
    int near_t;
    logic [7:0] tgt;
    logic sens;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    stop_at = requests_sent + n_req;
    while (requests_sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 75) begin
        r = $urandom_range(99);
        if (r < 50) begin
          near_t = int'(hd_pos) + $urandom_range(16) - 8;
          tgt = 8'((near_t < 0) ? -near_t : near_t);
        end else if (r < 85) begin
          tgt = 8'($urandom_range(15));
        end else begin
          tgt = 8'($urandom);
        end
        if ($urandom_range(4) == 0) send_request(KIND_RECAL, tgt, 1'($urandom));
        else send_request(KIND_SEEK, tgt, 1'($urandom));
        while (hd_phase != PHASE_IDLE) begin
          r = $urandom_range(99);
          // While seeking, the sensor only comes on near track 0, so long seeks still finish.
          if (hd_phase == PHASE_HOMING) sens = ($urandom_range(7) == 0);
          else sens = (hd_pos <= 2) && ($urandom_range(3) == 0);
          if (r < 3) send_request(KIND_SEEK, 8'($urandom), 1'($urandom));
          else if (r < 5) send_request(KIND_RECAL, 8'($urandom), 1'($urandom));
          else if (r < 7) send_request(KIND_UNUSED, 8'($urandom), 1'($urandom));
          else send_request(KIND_SLOT, 8'($urandom), sens);
        end
      end else begin
        send_request(2'($urandom_range(3)), 8'($urandom), 1'($urandom));
      end
    end
  endtask

  task automatic test_directed();
    send_request(KIND_SLOT, 8'd0, 1'b1);       // slot while idle
    send_request(KIND_UNUSED, 8'd255, 1'b1);
    send_request(KIND_SEEK, 8'd5, 1'b0);       // not homed yet, so it homes first
    send_request(KIND_SEEK, 8'd255, 1'b1);     // ignored while busy
    send_request(KIND_SLOT, 8'd0, 1'b0);
    send_request(KIND_RECAL, 8'd0, 1'b0);      // ignored while busy
    send_request(KIND_UNUSED, 8'd0, 1'b0);
    send_request(KIND_SLOT, 8'd0, 1'b1);
    repeat (5) send_request(KIND_SLOT, 8'd255, 1'b0);
    send_request(KIND_SEEK, 8'd5, 1'b0);       // already on target
    send_request(KIND_SEEK, 8'd0, 1'b0);       // goal zero always homes
    send_request(KIND_SLOT, 8'd0, 1'b1);
    wait_results_drained();
    write_reg(REG_INNER_TRACK_BOUNDARY, 8'd3);
    send_request(KIND_SEEK, 8'd3, 1'b0);
    send_request(KIND_SLOT, 8'd0, 1'b0);
    send_request(KIND_SLOT, 8'd0, 1'b1);       // sensor resync while seeking
    send_request(KIND_SLOT, 8'd0, 1'b0);
    send_request(KIND_SLOT, 8'd0, 1'b0);
    send_request(KIND_SEEK, 8'd1, 1'b0);
    repeat (2) send_request(KIND_SLOT, 8'd0, 1'b0);
    wait_results_drained();
    write_reg(REG_HOME_STEP_LIMIT, 8'd0);
    send_request(KIND_RECAL, 8'd0, 1'b0);
    send_request(KIND_SLOT, 8'd0, 1'b0);       // zero limit gives up at once
    wait_results_drained();
    write_reg(REG_HOME_STEP_LIMIT, 8'd2);
    send_request(KIND_SEEK, 8'd0, 1'b0);
    repeat (2) send_request(KIND_SLOT, 8'd0, 1'b0);
    send_request(KIND_SLOT, 8'd0, 1'b1);       // limit reached, sensor ignored
    wait_results_drained();
    write_reg(REG_HOME_STEP_LIMIT, HOME_STEP_LIMIT_RESET);
    write_reg(REG_INNER_TRACK_BOUNDARY, INNER_TRACK_BOUNDARY_RESET);
  endtask

  task automatic test_idle_phases();
    run_traffic(300, 0, 0);
    wait_results_drained();
    write_reg(REG_HOME_STEP_LIMIT, 8'd255);
    write_reg(REG_INNER_TRACK_BOUNDARY, 8'd255);
    run_traffic(300, 83, 0);
    wait_results_drained();
    write_reg(REG_HOME_STEP_LIMIT, 8'd1);
    write_reg(REG_INNER_TRACK_BOUNDARY, 8'd0);
    run_traffic(300, 0, 83);
    wait_results_drained();
    write_reg(REG_HOME_STEP_LIMIT, 8'd3);
    write_reg(REG_INNER_TRACK_BOUNDARY, 8'd16);
    run_traffic(250, 6, 6);
    wait_results_drained();
  endtask

  task automatic test_backpressure();
    write_reg(REG_HOME_STEP_LIMIT, 8'd20);
    write_reg(REG_INNER_TRACK_BOUNDARY, 8'd8);
    // The sender keeps offering while the receiver is held off.
    hold_off_cycles = 300;
    run_traffic(150, 0, 0);
    wait_results_drained();
    run_traffic(100, 0, 0);
    wait_results_drained();
  endtask

  task automatic test_config_sweep();
    repeat (3) begin
      write_reg(REG_HOME_STEP_LIMIT, 8'($urandom_range(1, 255)));
      write_reg(REG_INNER_TRACK_BOUNDARY, 8'($urandom));
      run_traffic(150, ($urandom_range(1) != 0) ? 83 : 0, ($urandom_range(1) != 0) ? 83 : 0);
      wait_results_drained();
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    kind = KIND_SEEK;
    target_track = '0;
    track0_sensor = 1'b0;
    hd_phase = PHASE_IDLE;
    hd_homed = 1'b0;
    hd_pos = '0;
    hd_goal = '0;
    hd_home_steps = '0;
    hd_found = 1'b0;
    hd_inner = 1'b0;
    step_limit = HOME_STEP_LIMIT_RESET;
    inner_boundary = INNER_TRACK_BOUNDARY_RESET;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_idle_phases();
    test_backpressure();
    test_config_sweep();

    wait_results_drained();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
